/* sv/msmf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package msmf_pkg;

  // Fixed field widths of the request and result channels.
  localparam int WORD_W = 64;
  localparam int NODE_W = 10;
  localparam int SLOT_W = 3;
  localparam int NID_W  = 10;
  localparam int DEGIN_W = 4;
  localparam int RND_W  = 5;
  localparam int OP_W   = 3;

  // Wide enough for the random value plus the largest degree, and for twice a count.
  localparam int THR_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_WR_SPIN = 3'd0,
    OP_WR_SLOT = 3'd1,
    OP_WR_DEG  = 3'd2,
    OP_FLIP    = 3'd3,
    OP_RD_SPIN = 3'd4
  } op_e;

  typedef struct packed {
    logic clr;
    logic acc;
  } cnt_ctrl_t;

endpackage

`default_nettype wire

/* sv/msmf_node_store.sv */
`timescale 1ns / 1ps
`default_nettype none

module msmf_node_store #(
  parameter int NODES    = 1024,
  parameter int REPLICAS = 64,
  parameter int DEG_W    = 4
) (
  input  wire logic                        clk_i,
  input  wire logic                        we_spin_i,
  input  wire logic                        we_deg_i,
  input  wire logic [$clog2(NODES)-1:0]    waddr_i,
  input  wire logic [REPLICAS-1:0]         wspin_i,
  input  wire logic [DEG_W-1:0]            wdeg_i,
  input  wire logic                        re_i,
  input  wire logic [$clog2(NODES)-1:0]    raddr_i,
  output logic      [REPLICAS-1:0]         rspin_o,
  output logic      [DEG_W-1:0]            rdeg_o
);

  logic [REPLICAS-1:0] spin_mem [NODES];
  logic [DEG_W-1:0]    deg_mem  [NODES];
  logic [REPLICAS-1:0] rspin_q;
  logic [DEG_W-1:0]    rdeg_q;

  always_ff @(posedge clk_i) begin
    if (we_spin_i) begin
      spin_mem[waddr_i] <= wspin_i;
    end
    if (we_deg_i) begin
      deg_mem[waddr_i] <= wdeg_i;
    end
  end

  // Read data holds between reads so the sequencer can sample it late.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rspin_q <= spin_mem[raddr_i];
      rdeg_q  <= deg_mem[raddr_i];
    end
  end

  assign rspin_o = rspin_q;
  assign rdeg_o  = rdeg_q;

endmodule

`default_nettype wire

/* sv/msmf_slot_store.sv */
`timescale 1ns / 1ps
`default_nettype none

module msmf_slot_store
  import msmf_pkg::*;
#(
  parameter int SLOTS    = 8192,
  parameter int REPLICAS = 64
) (
  input  wire logic                      clk_i,
  input  wire logic                      we_i,
  input  wire logic [$clog2(SLOTS)-1:0]  waddr_i,
  input  wire logic [NID_W-1:0]          wnid_i,
  input  wire logic [REPLICAS-1:0]       wcoup_i,
  input  wire logic                      re_i,
  input  wire logic [$clog2(SLOTS)-1:0]  raddr_i,
  output logic      [NID_W-1:0]          rnid_o,
  output logic      [REPLICAS-1:0]       rcoup_o
);

  // Each entry packs the neighbor id above its coupling word.
  logic [NID_W+REPLICAS-1:0] slot_mem [SLOTS];
  logic [NID_W+REPLICAS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      slot_mem[waddr_i] <= {wnid_i, wcoup_i};
    end
    if (re_i) begin
      rdata_q <= slot_mem[raddr_i];
    end
  end

  assign rnid_o  = rdata_q[NID_W+REPLICAS-1:REPLICAS];
  assign rcoup_o = rdata_q[REPLICAS-1:0];

endmodule

`default_nettype wire

/* sv/msmf_count.sv */
`timescale 1ns / 1ps
`default_nettype none

module msmf_count
  import msmf_pkg::*;
#(
  parameter int REPLICAS   = 64,
  parameter int MAX_DEGREE = 8
) (
  input  wire logic                               clk_i,
  input  wire cnt_ctrl_t                          ctrl_i,
  input  wire logic [REPLICAS-1:0]                x_i,
  input  wire logic [RND_W-1:0]                   rnd_i,
  input  wire logic [$clog2(MAX_DEGREE+1)-1:0]    deg_i,
  output logic      [REPLICAS-1:0]                mask_o
);

  localparam int CW = $clog2(MAX_DEGREE + 1);

  logic [CW-1:0]    cnt_q [REPLICAS];
  logic [THR_W-1:0] limit;

  // One unsatisfied-bond counter per replica.
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < REPLICAS; r++) begin
      if (ctrl_i.clr) begin
        cnt_q[r] <= '0;
      end else if (ctrl_i.acc) begin
        cnt_q[r] <= cnt_q[r] + CW'(x_i[r]);
      end
    end
  end

  assign limit = THR_W'(rnd_i) + THR_W'(deg_i);

  always_comb begin
    for (int r = 0; r < REPLICAS; r++) begin
      mask_o[r] = (THR_W'(cnt_q[r]) << 1) <= limit;
    end
  end

endmodule

`default_nettype wire

/* sv/multispin_metropolis_flip.sv */
`timescale 1ns / 1ps
`default_nettype none
// Metropolis flip engine for a plus-or-minus J spin glass, one replica per bit.
// Requests enter on in_valid_i / in_stall_o with op, node, slot, neighbor id,
// degree, word and random value as separate ports. Every request produces one
// result (spin word of the node after the request, and the mask of flipped
// replicas) on out_valid_o / out_stall_i.
// Requests are handled one at a time. Loads, reads and flips that take every
// replica go through the execute, self-read and done states; a flip that
// counts neighbors reads the neighbor slots one per cycle and each neighbor
// spin word then goes through the single read port of the spin memory.
// The result sits in an output register, so the next request is taken while a
// stalled result waits; a request that finishes before the receiver frees that
// register holds in place until it does.
// Reset clears the sequencer and the output register only. The memories are not
// cleared: a node, slot or degree must be written before it is used.
module multispin_metropolis_flip
  import msmf_pkg::*;
#(
  parameter int NODES      = 1024,
  parameter int MAX_DEGREE = 8,
  parameter int REPLICAS   = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [OP_W-1:0]    op_i,
  input  wire logic [NODE_W-1:0]  node_i,
  input  wire logic [SLOT_W-1:0]  slot_i,
  input  wire logic [NID_W-1:0]   neighbor_id_i,
  input  wire logic [DEGIN_W-1:0] degree_i,
  input  wire logic [WORD_W-1:0]  word_i,
  input  wire logic [RND_W-1:0]   rand_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic      [WORD_W-1:0]  spin_word_o,
  output logic      [WORD_W-1:0]  flip_mask_o
);

  localparam int AW    = $clog2(NODES);
  localparam int SLOTS = NODES * MAX_DEGREE;
  localparam int SW    = $clog2(SLOTS);
  localparam int KW    = $clog2(MAX_DEGREE + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SELF,
    S_LOOP,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  // Request registers.
  logic [OP_W-1:0]    op_q;
  logic [NODE_W-1:0]  node_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [NID_W-1:0]   nid_q;
  logic [DEGIN_W-1:0] degin_q;
  logic [WORD_W-1:0]  word_q;
  logic [RND_W-1:0]   rnd_q;

  logic [REPLICAS-1:0] self_q, self_d;
  logic [KW-1:0]       deg_q, deg_d;
  logic [KW-1:0]       iss_k_q, iss_k_d;
  logic                p1_valid_q, p1_valid_d;
  logic                p2_valid_q, p2_valid_d;
  logic                p2_nz_q, p2_nz_d;
  logic [REPLICAS-1:0] p2_coup_q, p2_coup_d;
  logic [WORD_W-1:0]   res_spin_q, res_spin_d;
  logic [WORD_W-1:0]   res_mask_q, res_mask_d;
  logic                out_valid_q, out_valid_d;
  logic [WORD_W-1:0]   out_spin_q, out_spin_d;
  logic [WORD_W-1:0]   out_mask_q, out_mask_d;

  logic                in_take;
  logic                out_take;
  logic                node_ok;
  logic [KW-1:0]       deg_sat;

  // Node store port signals.
  logic                ns_we_spin, ns_we_deg, ns_re;
  logic [AW-1:0]       ns_raddr;
  logic [REPLICAS-1:0] ns_wspin;
  logic [REPLICAS-1:0] ns_rspin;
  logic [KW-1:0]       ns_rdeg;

  // Slot store port signals.
  logic                ss_we, ss_re;
  logic [SW-1:0]       ss_waddr, ss_raddr;
  logic [NID_W-1:0]    ss_rnid;
  logic [REPLICAS-1:0] ss_rcoup;

  cnt_ctrl_t           cnt_ctrl;
  logic [REPLICAS-1:0] cnt_x;
  logic [REPLICAS-1:0] flip_mask;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;
  assign node_ok    = (32'(node_q) < NODES);
  assign deg_sat    = (32'(degin_q) > MAX_DEGREE) ? KW'(MAX_DEGREE) : KW'(degin_q);
  assign ss_waddr   = SW'(32'(node_q) * MAX_DEGREE + 32'(slot_q));

  always_comb begin
    state_d     = state_q;
    self_d      = self_q;
    deg_d       = deg_q;
    iss_k_d     = iss_k_q;
    p1_valid_d  = 1'b0;
    p2_valid_d  = 1'b0;
    p2_nz_d     = p2_nz_q;
    p2_coup_d   = p2_coup_q;
    res_spin_d  = res_spin_q;
    res_mask_d  = res_mask_q;
    out_valid_d = out_valid_q && !out_take;
    out_spin_d  = out_spin_q;
    out_mask_d  = out_mask_q;

    ns_we_spin  = 1'b0;
    ns_we_deg   = 1'b0;
    ns_wspin    = REPLICAS'(word_q);
    ns_re       = 1'b0;
    ns_raddr    = AW'(node_q);
    ss_we       = 1'b0;
    ss_re       = 1'b0;
    ss_raddr    = SW'(32'(node_q) * MAX_DEGREE + 32'(iss_k_q));
    cnt_ctrl    = '0;
    cnt_x       = self_q ^ (p2_nz_q ? ns_rspin : '0) ^ p2_coup_q;

    case (state_q)
      S_IDLE: begin
        if (in_take) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        if (!node_ok) begin
          res_spin_d = '0;
          res_mask_d = '0;
          state_d    = S_DONE;
        end else begin
          case (op_q)
            OP_WR_SPIN: ns_we_spin = 1'b1;
            OP_WR_SLOT: ss_we      = (32'(slot_q) < MAX_DEGREE);
            OP_WR_DEG:  ns_we_deg  = 1'b1;
            default:    ;
          endcase
          ns_re   = 1'b1;
          state_d = S_SELF;
        end
      end

      S_SELF: begin
        self_d     = ns_rspin;
        deg_d      = ns_rdeg;
        res_mask_d = '0;
        if (op_q == OP_WR_SPIN) begin
          res_spin_d = WORD_W'(REPLICAS'(word_q));
          state_d    = S_DONE;
        end else if (op_q != OP_FLIP) begin
          res_spin_d = WORD_W'(ns_rspin);
          state_d    = S_DONE;
        end else if (THR_W'(rnd_q) >= THR_W'(ns_rdeg)) begin
          // Every replica is accepted without looking at the neighbors.
          ns_we_spin = 1'b1;
          ns_wspin   = ~ns_rspin;
          res_spin_d = WORD_W'(~ns_rspin);
          res_mask_d = WORD_W'({REPLICAS{1'b1}});
          state_d    = S_DONE;
        end else begin
          iss_k_d      = '0;
          cnt_ctrl.clr = 1'b1;
          state_d      = S_LOOP;
        end
      end

      S_LOOP: begin
        // Three-step pipeline: slot read, neighbor spin read, count.
        if (iss_k_q != deg_q) begin
          ss_re      = 1'b1;
          iss_k_d    = iss_k_q + KW'(1);
          p1_valid_d = 1'b1;
        end
        if (p1_valid_q) begin
          ns_re      = 1'b1;
          ns_raddr   = AW'(ss_rnid);
          p2_valid_d = 1'b1;
          p2_nz_d    = (32'(ss_rnid) < NODES);
          p2_coup_d  = ss_rcoup;
        end
        if (p2_valid_q) begin
          cnt_ctrl.acc = 1'b1;
        end
        if ((iss_k_q == deg_q) && !p1_valid_q && !p2_valid_q) begin
          ns_we_spin = 1'b1;
          ns_wspin   = self_q ^ flip_mask;
          res_spin_d = WORD_W'(self_q ^ flip_mask);
          res_mask_d = WORD_W'(flip_mask);
          state_d    = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_take) begin
          out_valid_d = 1'b1;
          out_spin_d  = res_spin_q;
          out_mask_d  = res_mask_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      iss_k_q     <= '0;
      p1_valid_q  <= 1'b0;
      p2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_spin_q  <= '0;
      out_mask_q  <= '0;
    end else begin
      state_q     <= state_d;
      iss_k_q     <= iss_k_d;
      p1_valid_q  <= p1_valid_d;
      p2_valid_q  <= p2_valid_d;
      out_valid_q <= out_valid_d;
      out_spin_q  <= out_spin_d;
      out_mask_q  <= out_mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q    <= op_i;
      node_q  <= node_i;
      slot_q  <= slot_i;
      nid_q   <= neighbor_id_i;
      degin_q <= degree_i;
      word_q  <= word_i;
      rnd_q   <= rand_value_i;
    end
    self_q     <= self_d;
    deg_q      <= deg_d;
    p2_nz_q    <= p2_nz_d;
    p2_coup_q  <= p2_coup_d;
    res_spin_q <= res_spin_d;
    res_mask_q <= res_mask_d;
  end

  msmf_node_store #(
    .NODES    (NODES),
    .REPLICAS (REPLICAS),
    .DEG_W    (KW)
  ) u_node_store (
    .clk_i     (clk_i),
    .we_spin_i (ns_we_spin),
    .we_deg_i  (ns_we_deg),
    .waddr_i   (AW'(node_q)),
    .wspin_i   (ns_wspin),
    .wdeg_i    (deg_sat),
    .re_i      (ns_re),
    .raddr_i   (ns_raddr),
    .rspin_o   (ns_rspin),
    .rdeg_o    (ns_rdeg)
  );

  msmf_slot_store #(
    .SLOTS    (SLOTS),
    .REPLICAS (REPLICAS)
  ) u_slot_store (
    .clk_i   (clk_i),
    .we_i    (ss_we),
    .waddr_i (ss_waddr),
    .wnid_i  (nid_q),
    .wcoup_i (REPLICAS'(word_q)),
    .re_i    (ss_re),
    .raddr_i (ss_raddr),
    .rnid_o  (ss_rnid),
    .rcoup_o (ss_rcoup)
  );

  msmf_count #(
    .REPLICAS   (REPLICAS),
    .MAX_DEGREE (MAX_DEGREE)
  ) u_count (
    .clk_i  (clk_i),
    .ctrl_i (cnt_ctrl),
    .x_i    (cnt_x),
    .rnd_i  (rnd_q),
    .deg_i  (deg_q),
    .mask_o (flip_mask)
  );

  assign out_valid_o = out_valid_q;
  assign spin_word_o = out_spin_q;
  assign flip_mask_o = out_mask_q;

  // A counted neighbor must come through the neighbor spin read step that follows a slot read.
  a_pipe_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p2_valid_q |-> $past(p1_valid_q))
    else $error("neighbor spin consumed without a preceding slot read");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOP) |-> (iss_k_q <= deg_q))
    else $error("slot reads issued beyond the node degree");

  a_mask_flip_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DONE) && (res_mask_q != '0)) |-> (op_q == OP_FLIP))
    else $error("nonzero flip mask for a request that is not a flip");

  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DONE) && !node_ok) |-> ((res_spin_q == '0) && (res_mask_q == '0)))
    else $error("out-of-range node returned a nonzero result");

endmodule

`default_nettype wire
